>>> hw/rtl/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned FILL_W  = 5;
	localparam int unsigned CMD_W   = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_POP_FRONT  = 3'd1,
		CMD_PEEK_FRONT = 3'd2,
		CMD_PUSH_BACK  = 3'd3,
		CMD_POP_BACK   = 3'd4,
		CMD_PEEK_BACK  = 3'd5,
		CMD_EMPTY_Q    = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// result fields other than the read word
	typedef struct packed {
		logic              read_valid;
		logic              is_empty;
		status_t           status;
		logic [FILL_W-1:0] fill_count;
	} info_t;

endpackage

>>> hw/rtl/cdq_store.sv
`timescale 1ns / 1ps

module cdq_store #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH)-1:0]       waddr,
	input  logic [cdq_pkg::WORD_W-1:0]     wdata,
	input  logic                           re,
	input  logic [$clog2(DEPTH)-1:0]       raddr,
	output logic [cdq_pkg::WORD_W-1:0]     rdata
);

	logic [cdq_pkg::WORD_W-1:0] mem [DEPTH];
	logic [cdq_pkg::WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/cdq_ctrl.sv
`timescale 1ns / 1ps

module cdq_ctrl #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [cdq_pkg::CMD_W-1:0]      cmd,
	input  logic [cdq_pkg::WORD_W-1:0]     push_value,
	output logic                           we,
	output logic [$clog2(DEPTH)-1:0]       waddr,
	output logic [cdq_pkg::WORD_W-1:0]     wdata,
	output logic                           re,
	output logic [$clog2(DEPTH)-1:0]       raddr,
	output cdq_pkg::info_t                 info
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [AW-1:0]    head_q, tail_q, head_d, tail_d;
	logic [CW-1:0]    count_q, count_d;
	logic [CW+4:0]    count_ext;
	logic             wr_en, rd_en, rd_ok;
	logic [AW-1:0]    wr_addr, rd_addr;
	cdq_pkg::status_t st;

	function automatic logic [AW-1:0] step_up(input logic [AW-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] step_down(input logic [AW-1:0] p);
		return (p == '0) ? LAST_IDX : p - 1'b1;
	endfunction

	always_comb begin
		head_d  = head_q;
		tail_d  = tail_q;
		count_d = count_q;
		wr_en   = 1'b0;
		wr_addr = '0;
		rd_en   = 1'b0;
		rd_addr = head_q;
		rd_ok   = 1'b0;
		st      = cdq_pkg::ST_DONE;
		unique case (cdq_pkg::cmd_t'(cmd))
			cdq_pkg::CMD_PUSH_FRONT, cdq_pkg::CMD_PUSH_BACK: begin
				if (count_q == FULL_CNT) begin
					st = cdq_pkg::ST_FULL;
				end else if (count_q == '0) begin
					head_d  = '0;
					tail_d  = '0;
					wr_en   = 1'b1;
					wr_addr = '0;
					count_d = CW'(1);
				end else if (cdq_pkg::cmd_t'(cmd) == cdq_pkg::CMD_PUSH_FRONT) begin
					head_d  = step_down(head_q);
					wr_en   = 1'b1;
					wr_addr = head_d;
					count_d = count_q + 1'b1;
				end else begin
					tail_d  = step_up(tail_q);
					wr_en   = 1'b1;
					wr_addr = tail_d;
					count_d = count_q + 1'b1;
				end
			end
			cdq_pkg::CMD_POP_FRONT, cdq_pkg::CMD_POP_BACK: begin
				if (count_q == '0) begin
					st = cdq_pkg::ST_EMPTY;
				end else begin
					if (cdq_pkg::cmd_t'(cmd) == cdq_pkg::CMD_POP_FRONT) begin
						head_d = step_up(head_q);
					end else begin
						tail_d = step_down(tail_q);
					end
					count_d = count_q - 1'b1;
				end
			end
			cdq_pkg::CMD_PEEK_FRONT, cdq_pkg::CMD_PEEK_BACK: begin
				if (count_q == '0) begin
					st = cdq_pkg::ST_EMPTY;
				end else begin
					rd_en   = 1'b1;
					rd_ok   = 1'b1;
					rd_addr = (cdq_pkg::cmd_t'(cmd) == cdq_pkg::CMD_PEEK_FRONT) ?
						head_q : tail_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (accept) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

	assign count_ext = (CW + 5)'(count_d);

	assign we    = accept & wr_en;
	assign waddr = wr_addr;
	assign wdata = push_value;
	assign re    = accept & rd_en;
	assign raddr = rd_addr;

	assign info.read_valid = rd_ok;
	assign info.is_empty   = (count_d == '0);
	assign info.status     = st;
	assign info.fill_count = count_ext[cdq_pkg::FILL_W-1:0];

endmodule

>>> hw/rtl/cdq_out.sv
`timescale 1ns / 1ps

module cdq_out (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  cdq_pkg::info_t                 info,
	input  logic [cdq_pkg::WORD_W-1:0]     rdata,
	output logic                           in_ready,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [39:0]                    m_tdata,
	output logic                           m_tuser
);

	logic           valid_s1;
	cdq_pkg::info_t info_s1;
	logic           out_valid_q;
	logic [39:0]    out_data_q;
	logic           out_user_q;
	logic           advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
		if (advance) begin
			out_data_q <= {info_s1.fill_count, info_s1.status, info_s1.is_empty,
				(info_s1.read_valid ? rdata : '0)};
			out_user_q <= info_s1.read_valid;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

>>> hw/rtl/circular_deque_core.sv
`timescale 1ns / 1ps

// Double-ended queue of DEPTH signed 32-bit words in a circular store. One
// command per cycle is accepted while the output is not stalled, and each
// produces exactly one result transaction via the stage-one registers (the
// store's registered read port among them) and then the output register.
// Push into a full queue is dropped (status 1), pop or peek on an empty queue is
// ignored (status 2). fill_count shows the low five bits of the word count.

module circular_deque_core #(
	parameter int unsigned DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // push_value[31:0]
	input  logic [2:0]  s_tuser,   // cmd[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // read_value[31:0], is_empty[32], status[34:33],
	                               // fill_count[39:35]
	output logic        m_tuser    // read_valid
);

	localparam int unsigned AW = $clog2(DEPTH);

	logic                       accept;
	logic                       we, re;
	logic [AW-1:0]              waddr, raddr;
	logic [cdq_pkg::WORD_W-1:0] wdata, rdata;
	cdq_pkg::info_t             info;

	assign accept = s_tvalid & s_tready;

	cdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cmd        (s_tuser),
		.push_value (s_tdata),
		.we         (we),
		.waddr      (waddr),
		.wdata      (wdata),
		.re         (re),
		.raddr      (raddr),
		.info       (info)
	);

	cdq_store #(.DEPTH(DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	cdq_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.info     (info),
		.rdata    (rdata),
		.in_ready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> hw/rtl/cdq_checker.sv
`timescale 1ns / 1ps

module cdq_checker #(
	parameter int unsigned DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tuser
);

	a_peek_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[34:33] == cdq_pkg::ST_DONE)
		else $error("peek result with nonzero status");

	a_zero_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:0] == 32'd0)
		else $error("read word not zero without peek");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[34:33] == cdq_pkg::ST_FULL |-> m_tdata[39:35] == 5'(DEPTH))
		else $error("dropped push while not full");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (DEPTH < 32) |-> m_tdata[32] == (m_tdata[39:35] == 5'd0))
		else $error("empty flag disagrees with count");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled transaction changed");

endmodule

bind circular_deque_core cdq_checker #(.DEPTH(DEPTH)) u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
